FILE: rtl/fmbq_pkg.sv
// Shared constants, command and status codes, and controller types for the queue.
`timescale 1ns / 1ps

package fmbq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT  = 3'd0,
    FN_PUSH_MIDDLE = 3'd1,
    FN_PUSH_BACK   = 3'd2,
    FN_POP_FRONT   = 3'd3,
    FN_POP_MIDDLE  = 3'd4,
    FN_POP_BACK    = 3'd5
  } func_t;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // apply the captured item to the cell array
  } dp_cmd_t;

  // Status from the controller to the outside.
  typedef struct packed {
    logic busy;
  } ctl_stat_t;

endpackage

FILE: rtl/fmbq_ctrl.sv
// Controller state machine: sequences capture and execution of one item.
`timescale 1ns / 1ps

module fmbq_ctrl
  import fmbq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output dp_cmd_t   cmd,
  output ctl_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load  = start && (state_r == S_IDLE);
  assign cmd.exec  = (state_r == S_EXEC);
  assign stat.busy = (state_r != S_IDLE);

endmodule

FILE: rtl/fmbq_dp.sv
// Datapath: command register, shifting cell array, fill count and result registers.
`timescale 1ns / 1ps

module fmbq_dp
  import fmbq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  logic [FUNC_W-1:0]             in_func,
  input  logic signed [VALUE_WIDTH-1:0] in_push_value,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_pop_value,
  output logic [STATUS_W-1:0]           out_status,
  output logic [CNT_W-1:0]              out_fill_count
);

  logic [FUNC_W-1:0]      func_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [VALUE_WIDTH-1:0] cells_r [DEPTH];
  logic [VALUE_WIDTH-1:0] cells_nxt [DEPTH];
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] pop_r, pop_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [CNT_W-1:0]       fill_r;

  logic             is_push, is_pop, full, empty, do_push, do_pop;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] cnt_m1;

  assign is_push = (func_r == FN_PUSH_FRONT) || (func_r == FN_PUSH_MIDDLE) ||
                   (func_r == FN_PUSH_BACK);
  assign is_pop  = (func_r == FN_POP_FRONT) || (func_r == FN_POP_MIDDLE) ||
                   (func_r == FN_POP_BACK);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = is_push && !full;
  assign do_pop  = is_pop && !empty;
  assign cnt_m1  = count_r - CNT_W'(1);

  // Position in the array that the command touches.
  always_comb begin
    case (func_r)
      FN_PUSH_MIDDLE: pos = count_r >> 1;
      FN_PUSH_BACK:   pos = count_r;
      FN_POP_MIDDLE:  pos = cnt_m1 >> 1;
      FN_POP_BACK:    pos = cnt_m1;
      default:        pos = '0;
    endcase
  end

  // Every cell either holds, loads the new value, or takes a neighbor.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_push) begin
        if (CNT_W'(i) == pos) begin
          cells_nxt[i] = val_r;
        end else if ((CNT_W'(i) > pos) && (i > 0)) begin
          cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop) begin
        if ((CNT_W'(i) >= pos) && (i < DEPTH - 1)) begin
          cells_nxt[i] = cells_r[(i < DEPTH - 1) ? i + 1 : DEPTH - 1];
        end
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    pop_nxt    = '0;
    status_nxt = ST_DONE;
    if (is_push) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_pop) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
        pop_nxt    = '1;
      end else begin
        count_nxt = cnt_m1;
        pop_nxt   = cells_r[pos[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      val_r  <= in_push_value;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
      pop_r    <= pop_nxt;
      status_r <= status_nxt;
      fill_r   <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pop_value  = signed'(pop_r);
  assign out_status     = status_r;
  assign out_fill_count = fill_r;

endmodule

FILE: rtl/front_middle_back_queue.sv
// Top level of the front/middle/back queue: controller, datapath and checks.
`timescale 1ns / 1ps

// The queue holds up to DEPTH signed values in order and takes one command
// per item: push or pop at the front, the middle or the back. A push in the
// middle lands at position floor(count/2); a pop in the middle removes the
// frontmost of the two middles when the count is even.
// An item is accepted at a rising edge where start is high and busy is low.
// Busy then stays high for one cycle while the cell array shifts, and the
// result appears on the out_ ports, marked by out_valid for exactly one cycle,
// once the shift is done. The receiver cannot hold a result off,
// and no result is ever repeated.
// An item is first captured and then executed, with every affected cell
// moving at once; no new item is taken while busy, and the next start is
// taken in the same cycle that shows the previous result.
// A pop on an empty queue returns -1 with the empty status; a push on a full
// queue is dropped with the full status. Unused command codes change nothing
// and report done. Reset (synchronous, active low) empties the queue and
// clears the strobe; stored values are not cleared, since only filled cells
// are ever read.
module front_middle_back_queue
  import fmbq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [FUNC_W-1:0]             in_func,
  input  logic signed [VALUE_WIDTH-1:0] in_push_value,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_pop_value,
  output logic [STATUS_W-1:0]           out_status,
  output logic [CNT_W-1:0]              out_fill_count
);

  dp_cmd_t   cmd;
  ctl_stat_t stat;

  // The controller decides when an item is captured and when it executes.
  fmbq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (cmd),
    .stat  (stat)
  );

  // The datapath owns the cells, the fill count and the result registers.
  fmbq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_func),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  assign busy = stat.busy;

`ifndef NO_ASSERTIONS
  // Every accepted item yields a result, marked by out_valid.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  // An accepted item makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // The fill count never exceeds the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_count <= CNT_W'(DEPTH)))
    else $error("fill count above capacity");

  // A pop on an empty queue reports -1 and an empty queue.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |->
      ((out_pop_value == -1) && (out_fill_count == '0)))
    else $error("empty pop reported wrong value or count");
`endif

endmodule

FILE: tb/fmbq_reply_checker.sv
// Checker for the queue: mirrors every accepted command and compares each reply.
`timescale 1ns / 1ps

module fmbq_reply_checker
  import fmbq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [FUNC_W-1:0]             in_func,
  input  logic signed [VALUE_WIDTH-1:0] in_push_value,
  input  logic                          out_valid,
  input  logic signed [VALUE_WIDTH-1:0] out_pop_value,
  input  logic [STATUS_W-1:0]           out_status,
  input  logic [CNT_W-1:0]              out_fill_count,
  output int                            error_count,
  output int                            replies_pending
);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] pop_value;
    logic [STATUS_W-1:0]           status;
    logic [CNT_W-1:0]              fill_count;
  } queue_reply_t;

  // Shadow copy of the stored values, front at index 0.
  logic signed [VALUE_WIDTH-1:0] shadow_cells [DEPTH];
  int                            shadow_count;
  queue_reply_t                  awaited_replies [$];
  int                            mismatches;

  initial begin
    error_count     = 0;
    replies_pending = 0;
    mismatches      = 0;
    shadow_count    = 0;
  end

  // Applies one command to the shadow store and returns the reply it should give.
  function automatic queue_reply_t apply_command(logic [FUNC_W-1:0]             fn,
                                                 logic signed [VALUE_WIDTH-1:0] value);
    queue_reply_t reply;
    int           pos;
    int           i;
    reply.pop_value = '0;
    reply.status    = ST_DONE;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_MIDDLE, FN_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          if (fn == FN_PUSH_FRONT) pos = 0;
          else if (fn == FN_PUSH_MIDDLE) pos = shadow_count / 2;
          else pos = shadow_count;
          for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[pos] = value;
          shadow_count++;
        end
      end
      FN_POP_FRONT, FN_POP_MIDDLE, FN_POP_BACK: begin
        if (shadow_count == 0) begin
          reply.pop_value = -1;
          reply.status    = ST_EMPTY;
        end else begin
          if (fn == FN_POP_FRONT) pos = 0;
          else if (fn == FN_POP_MIDDLE) pos = (shadow_count - 1) / 2;
          else pos = shadow_count - 1;
          reply.pop_value = shadow_cells[pos];
          for (i = pos; i < shadow_count - 1; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    reply.fill_count = shadow_count[CNT_W-1:0];
    return reply;
  endfunction

  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_replies.delete();
    end else begin
      // Replies are checked before the command taken at this same edge is queued.
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: reply with none awaited: pop_value %0d status %0d fill_count %0d",
                   $time, out_pop_value, out_status, out_fill_count);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %0d, actual %0d",
                     $time, want.pop_value, out_pop_value);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, out_status);
            mismatches++;
          end
          if (out_fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d, actual %0d",
                     $time, want.fill_count, out_fill_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) awaited_replies.push_back(apply_command(in_func, in_push_value));
    end
    error_count     <= mismatches;
    replies_pending <= awaited_replies.size();
  end

endmodule

FILE: tb/tb_front_middle_back_queue.sv
// Testbench top for the queue: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module tb_front_middle_back_queue;
  import fmbq_pkg::*;

  // Codes 6 and 7 are not commands; the queue must leave its contents alone.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 550;
  localparam int PHASE_ITEMS  = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          start         = 1'b0;
  logic [FUNC_W-1:0]             in_func       = FN_PUSH_FRONT;
  logic signed [VALUE_WIDTH-1:0] in_push_value = '0;
  logic                          busy;
  logic                          out_valid;
  logic signed [VALUE_WIDTH-1:0] out_pop_value;
  logic [STATUS_W-1:0]           out_status;
  logic [CNT_W-1:0]              out_fill_count;
  int                            error_count;
  int                            replies_pending;
  int                            cycle_count   = 0;

  // A 2 ns clock: 1 ns high, 1 ns low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  front_middle_back_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  // The checker sees the same ports as the queue and does all the predicting.
  fmbq_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_pop_value   (out_pop_value),
    .out_status      (out_status),
    .out_fill_count  (out_fill_count),
    .error_count     (error_count),
    .replies_pending (replies_pending)
  );

  // Watchdog: a hung handshake or a reply that never comes ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one command and returns at the edge where it is taken. Start is
  // left high, so a command that follows at once keeps it high without a dip.
  // Busy is read right after the edge, so it still holds its value from before
  // the edge, which is the value the queue used to decide on acceptance.
  task automatic send_command(input logic [FUNC_W-1:0]             fn,
                              input logic signed [VALUE_WIDTH-1:0] value);
    start         <= 1'b1;
    in_func       <= fn;
    in_push_value <= value;
    do @(posedge clk); while (busy);
  endtask

  // Drops start for a number of cycles. The command fields carry junk meanwhile,
  // which the queue must ignore.
  task automatic pause_cycles(input int cycles);
    start         <= 1'b0;
    in_func       <= FUNC_W'($urandom_range(0, 7));
    in_push_value <= $urandom();
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly random words, with the corner values mixed in now and then.
  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -1;
      3:       return 0;
      default: return $urandom();
    endcase
  endfunction

  // Chooses a command; push_pct sets how strongly the phase leans toward filling.
  function automatic logic [FUNC_W-1:0] pick_command(input int push_pct);
    if ($urandom_range(0, 99) < 3) return ($urandom_range(0, 1) == 0) ? FN_SPARE_6 : FN_SPARE_7;
    if ($urandom_range(0, 99) < push_pct) begin
      case ($urandom_range(0, 2))
        0:       return FN_PUSH_FRONT;
        1:       return FN_PUSH_MIDDLE;
        default: return FN_PUSH_BACK;
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return FN_POP_FRONT;
      1:       return FN_POP_MIDDLE;
      default: return FN_POP_BACK;
    endcase
  endfunction

  // Gap after a command. Mode 0 never idles, mode 1 idles often but briefly,
  // mode 2 idles now and then, mostly short with an occasional long stretch.
  task automatic maybe_idle(input int gap_mode);
    if (gap_mode == 1 && $urandom_range(0, 99) < 60) begin
      pause_cycles($urandom_range(1, 3));
    end else if (gap_mode == 2 && $urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 99) < 85) pause_cycles($urandom_range(1, 3));
      else pause_cycles($urandom_range(8, 30));
    end
  endtask

  initial begin
    int taken;
    int push_pct;
    int gap_mode;
    logic [FUNC_W-1:0] fn;

    // Synchronous reset, held low from the start and then released for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Pops of every kind on the empty queue come first, then the
    // two spare codes, which must change nothing.
    send_command(FN_POP_FRONT, 32'sh1234_5678);
    send_command(FN_POP_MIDDLE, 0);
    send_command(FN_POP_BACK, -1);
    send_command(FN_SPARE_6, 32'sh7FFF_FFFF);
    send_command(FN_SPARE_7, 32'sh8000_0000);
    // Extreme values in at every position, so the middle lands between them.
    send_command(FN_PUSH_FRONT, 32'sh8000_0000);
    send_command(FN_PUSH_BACK, 32'sh7FFF_FFFF);
    send_command(FN_PUSH_MIDDLE, 0);
    send_command(FN_PUSH_MIDDLE, -1);
    send_command(FN_PUSH_MIDDLE, 32'sh5555_AAAA);
    // Pop-middle with odd and then even fill, then the ends, down to empty.
    send_command(FN_POP_MIDDLE, 0);
    send_command(FN_POP_MIDDLE, 0);
    send_command(FN_POP_FRONT, 0);
    send_command(FN_POP_BACK, 0);
    send_command(FN_POP_MIDDLE, 0);
    send_command(FN_POP_MIDDLE, 0);

    // Random part, in phases that lean toward filling, draining or neither, so
    // the queue is driven into both the full and the empty corner repeatedly.
    // Spare codes are sent too but do not count toward the item total.
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      gap_mode = $urandom_range(0, 2);
      repeat (PHASE_ITEMS) begin
        fn = pick_command(push_pct);
        if (fn != FN_SPARE_6 && fn != FN_SPARE_7) taken++;
        send_command(fn, random_value());
        maybe_idle(gap_mode);
      end
    end

    // All commands are in: wait for the last replies, then a few more edges so
    // that a stray extra reply would still be seen.
    start <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
